@@ rtl/rtdb_pkg.sv @@
// Shared types, constants and the table builder for the transmittance blend/density block.
package rtdb_pkg;

  localparam int PIX_W  = 16;
  localparam int GAIN_W = 17;
  localparam int DENS_W = 16;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

  localparam int LOG_TABLE_ENTRIES_DEF = 256;

  // log10(2) in Q0.24
  localparam logic [22:0] DENS_K = 23'd5050445;
  localparam int DENS_SHIFT = 41;

  // Pipeline layout: three blend stages, then six density stages
  localparam int BLEND_STAGES = 3;
  localparam int DENS_STAGES  = 6;
  localparam int STG_BLEND    = 0;
  localparam int STG_DENS     = BLEND_STAGES;
  localparam int PIPE_STAGES  = BLEND_STAGES + DENS_STAGES;

  typedef enum logic [1:0] {
    CFG_GAIN_RED   = 2'd0,
    CFG_GAIN_GREEN = 2'd1,
    CFG_GAIN_BLUE  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [PIPE_STAGES-1:0] en;   // per-stage load enable
  } pipe_ctl_t;

  // Bitwise-squaring log2 of x (Q1.30, in [1,2]), Q.30 truncated. Elaboration only.
  function automatic logic [30:0] log2_q30(input logic [63:0] x_in);
    logic [63:0] x;
    logic [31:0] res;
    x   = x_in;
    res = '0;
    for (int k = 0; k < 2; k++) begin
      if (x >= (64'd1 << 31)) begin
        x   = x >> 1;
        res = res + (32'd1 << 30);
      end
    end
    for (int bitn = 29; bitn >= 0; bitn--) begin
      x = (x * x) >> 30;
      if (x >= (64'd1 << 31)) begin
        x         = x >> 1;
        res[bitn] = 1'b1;
      end
    end
    return res[30:0];
  endfunction

endpackage

@@ rtl/rtdb_ctrl.sv @@
// Valid tracking, per-stage load enables and frame marker for the pixel pipeline.
module rtdb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                pixel_valid,
  input  logic                final_pixel,
  input  logic                result_ready,
  output logic                pixel_ready,
  output logic                result_valid,
  output logic                end_of_frame,
  output rtdb_pkg::pipe_ctl_t ctl
);

  localparam int S = rtdb_pkg::PIPE_STAGES;

  logic [S-1:0] valid;
  logic [S-1:0] eop;
  logic [S-1:0] en;

  // A stage loads when it is empty or its contents move on; bubbles collapse.
  always_comb begin
    en[S-1] = !valid[S-1] || result_ready;
    for (int k = S - 2; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= pixel_valid;
      end
      for (int k = 1; k < S; k++) begin
        if (en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      eop[0] <= final_pixel;
    end
    for (int k = 1; k < S; k++) begin
      if (en[k]) begin
        eop[k] <= eop[k-1];
      end
    end
  end

  assign ctl.en        = en;
  assign pixel_ready   = en[0];
  assign result_valid  = valid[S-1];
  assign end_of_frame  = eop[S-1];

endmodule

@@ rtl/rtdb_blend.sv @@
// One colour channel of the gain blend: difference, gain multiply, candidate and domain check.
module rtdb_blend (
  input  logic                               clk,
  input  rtdb_pkg::pipe_ctl_t                ctl,
  input  logic [rtdb_pkg::PIX_W-1:0]         expected,
  input  logic [rtdb_pkg::PIX_W-1:0]         base,
  input  logic [rtdb_pkg::GAIN_W-1:0]        gain,
  output logic [rtdb_pkg::PIX_W-1:0]         cand,
  output logic                               cand_err
);

  localparam int PW = rtdb_pkg::PIX_W;
  localparam int GW = rtdb_pkg::GAIN_W;
  localparam int S0 = rtdb_pkg::STG_BLEND;

  // stage 1
  logic [PW-1:0] e1;
  logic [PW-1:0] diff1;
  logic [GW-1:0] g1;
  logic          ge1;
  logic          err1;
  // stage 2
  logic [PW-1:0]    e2;
  logic [PW+GW-1:0] prod2;
  logic             ge2;
  logic             err2;

  logic [PW+1:0]    up_sum;
  logic [PW+GW:0]   prod_rnd;
  logic [PW+1:0]    dec;
  logic [PW+1:0]    c_next;
  logic             err_next;

  always_ff @(posedge clk) begin
    if (ctl.en[S0]) begin
      e1    <= expected;
      ge1   <= base >= expected;
      diff1 <= (base >= expected) ? base - expected : expected - base;
      g1    <= gain;
      err1  <= (expected == '0) || (base == '0) || (gain == '0) ||
               (gain > rtdb_pkg::GAIN_ONE);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[S0+1]) begin
      e2    <= e1;
      ge2   <= ge1;
      prod2 <= (PW+GW)'(g1) * (PW+GW)'(diff1);
      err2  <= err1;
    end
  end

  // Rising blend truncates the step; falling blend rounds the decrement up.
  always_comb begin
    up_sum   = (PW+2)'(e2) + (PW+2)'(prod2[PW+GW-1:16]);
    prod_rnd = (PW+GW+1)'(prod2) + (PW+GW+1)'(17'h0FFFF);
    dec      = prod_rnd[PW+GW:16];
    if (ge2) begin
      c_next = up_sum;
    end else begin
      c_next = (dec >= (PW+2)'(e2)) ? '0 : (PW+2)'(e2) - dec;
    end
    err_next = err2 || (c_next == '0) || (c_next > (PW+2)'(18'h0FFFF));
  end

  always_ff @(posedge clk) begin
    if (ctl.en[S0+2]) begin
      cand     <= c_next[PW-1:0];
      cand_err <= err_next;
    end
  end

endmodule

@@ rtl/rtdb_density.sv @@
// One colour channel of -log10: normalise, table interpolate, scale by log10(2), round.
module rtdb_density #(
  parameter int LOG_TABLE_ENTRIES = rtdb_pkg::LOG_TABLE_ENTRIES_DEF
) (
  input  logic                              clk,
  input  rtdb_pkg::pipe_ctl_t               ctl,
  input  logic [rtdb_pkg::PIX_W-1:0]        cand,
  input  logic                              cand_err,
  output logic [rtdb_pkg::DENS_W-1:0]       density,
  output logic [rtdb_pkg::PIX_W-1:0]        trans,
  output logic                              err
);

  localparam int PW    = rtdb_pkg::PIX_W;
  localparam int S0    = rtdb_pkg::STG_DENS;
  localparam int IDX_W = $clog2(LOG_TABLE_ENTRIES + 1);
  localparam int POS_W = 15 + IDX_W;
  localparam int L2_W  = 35;
  localparam int LO_W  = 18;
  localparam int HI_W  = L2_W - LO_W;
  localparam int SUM_W = L2_W + 23 + 1;

  logic [30:0] log_tab [0:LOG_TABLE_ENTRIES];

  for (genvar i = 0; i <= LOG_TABLE_ENTRIES; i++) begin : g_tab
    localparam logic [63:0] X = ((64'(LOG_TABLE_ENTRIES) + 64'(i)) << 30) /
                                64'(LOG_TABLE_ENTRIES);
    localparam logic [30:0] ENTRY = rtdb_pkg::log2_q30(X);
    assign log_tab[i] = ENTRY;
  end

  function automatic logic [3:0] lead_one(input logic [PW-1:0] v);
    logic [3:0] p;
    p = '0;
    for (int i = 0; i < PW; i++) begin
      if (v[i]) begin
        p = 4'(i);
      end
    end
    return p;
  endfunction

  // sideband carried alongside every stage
  logic [PW-1:0] c1, c2, c3, c4, c5;
  logic          e1, e2, e3, e4, e5;

  // stage 1: normalise and index
  logic [3:0]       lz_p;
  logic [PW-1:0]    norm;
  logic [POS_W-1:0] pos_next;
  logic [IDX_W-1:0] idx1;
  logic [14:0]      rem1;
  logic [4:0]       sh1;
  // stage 2: table read
  logic [30:0]      t0_2;
  logic [30:0]      td2;
  logic [14:0]      rem2;
  logic [4:0]       sh2;
  // stage 3: interpolation product
  logic [30:0]      t0_3;
  logic [45:0]      ip_full;
  logic [30:0]      ip3;
  logic [4:0]       sh3;
  // stage 4: log2 of the reciprocal
  logic [31:0]      l_next;
  logic [L2_W-1:0]  l2_4;
  // stage 5: partial products of the log10(2) scale
  logic [LO_W+22:0] plo5;
  logic [HI_W+22:0] phi5;
  // stage 6
  logic [SUM_W-1:0] total;

  always_comb begin
    lz_p     = lead_one(cand);
    norm     = cand << (4'd15 - lz_p);
    pos_next = POS_W'(norm[14:0]) * POS_W'(LOG_TABLE_ENTRIES);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[S0]) begin
      idx1 <= pos_next[POS_W-1:15];
      rem1 <= pos_next[14:0];
      sh1  <= 5'd16 - 5'(lz_p);
      c1   <= cand;
      e1   <= cand_err;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[S0+1]) begin
      t0_2 <= log_tab[idx1];
      td2  <= log_tab[idx1 + IDX_W'(1)] - log_tab[idx1];
      rem2 <= rem1;
      sh2  <= sh1;
      c2   <= c1;
      e2   <= e1;
    end
  end

  assign ip_full = 46'(td2) * 46'(rem2);

  always_ff @(posedge clk) begin
    if (ctl.en[S0+2]) begin
      t0_3 <= t0_2;
      ip3  <= ip_full[45:15];
      sh3  <= sh2;
      c3   <= c2;
      e3   <= e2;
    end
  end

  assign l_next = 32'(t0_3) + 32'(ip3);

  always_ff @(posedge clk) begin
    if (ctl.en[S0+3]) begin
      l2_4 <= {sh3, 30'b0} - L2_W'(l_next);
      c4   <= c3;
      e4   <= e3;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[S0+4]) begin
      plo5 <= (LO_W+23)'(l2_4[LO_W-1:0]) * (LO_W+23)'(rtdb_pkg::DENS_K);
      phi5 <= (HI_W+23)'(l2_4[L2_W-1:LO_W]) * (HI_W+23)'(rtdb_pkg::DENS_K);
      c5   <= c4;
      e5   <= e4;
    end
  end

  // round to nearest at bit 41
  assign total = (SUM_W'(phi5) << LO_W) + SUM_W'(plo5) +
                 (SUM_W'(1) << (rtdb_pkg::DENS_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (ctl.en[S0+5]) begin
      density <= total[rtdb_pkg::DENS_SHIFT +: rtdb_pkg::DENS_W];
      trans   <= c5;
      err     <= e5;
    end
  end

endmodule

@@ rtl/rgb_transmittance_blend_density_top.sv @@
// Top level of the RGB transmittance blend and optical density pipeline.
//
//  channel  | handshake                 | carries
//  ---------+---------------------------+------------------------------------------
//  pixel    | pixel_valid / pixel_ready | expected_*, base_* (Q0.16), final_pixel
//  result   | result_valid/result_ready | density_* (Q3.13), transmittance_*, status,
//           |                           | end_of_frame
//  config   | cfg_we (no wait)          | cfg_index, cfg_data (17-bit Q1.16 gain)
//
// One pixel per clock sustained while result_ready stays high; result_valid marks a pixel
// that has passed nine register stages (three blend, six density, the last being the
// output register).
// The interpolation and log10(2) multiplies set the stage split.
// Reset clears the valid bits and loads all three gains with 1.0.
// Each stage holds under back-pressure only while it is full; empty stages keep
// filling, so pixel_ready drops only once the whole pipeline is occupied.
module rgb_transmittance_blend_density_top #(
  parameter int LOG_TABLE_ENTRIES = rtdb_pkg::LOG_TABLE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [rtdb_pkg::GAIN_W-1:0]   cfg_data,
  input  logic                          pixel_valid,
  output logic                          pixel_ready,
  input  logic [rtdb_pkg::PIX_W-1:0]    expected_red,
  input  logic [rtdb_pkg::PIX_W-1:0]    expected_green,
  input  logic [rtdb_pkg::PIX_W-1:0]    expected_blue,
  input  logic [rtdb_pkg::PIX_W-1:0]    base_red,
  input  logic [rtdb_pkg::PIX_W-1:0]    base_green,
  input  logic [rtdb_pkg::PIX_W-1:0]    base_blue,
  input  logic                          final_pixel,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [rtdb_pkg::DENS_W-1:0]   density_red,
  output logic [rtdb_pkg::DENS_W-1:0]   density_green,
  output logic [rtdb_pkg::DENS_W-1:0]   density_blue,
  output logic [rtdb_pkg::PIX_W-1:0]    transmittance_red,
  output logic [rtdb_pkg::PIX_W-1:0]    transmittance_green,
  output logic [rtdb_pkg::PIX_W-1:0]    transmittance_blue,
  output logic                          status,
  output logic                          end_of_frame
);

  localparam int PW = rtdb_pkg::PIX_W;
  localparam int DW = rtdb_pkg::DENS_W;
  localparam int GW = rtdb_pkg::GAIN_W;

  logic [GW-1:0] gain_red;
  logic [GW-1:0] gain_green;
  logic [GW-1:0] gain_blue;

  rtdb_pkg::pipe_ctl_t ctl;

  logic [PW-1:0] cand_r, cand_g, cand_b;
  logic          cerr_r, cerr_g, cerr_b;
  logic [DW-1:0] dens_r, dens_g, dens_b;
  logic [PW-1:0] tr_r, tr_g, tr_b;
  logic          err_r, err_g, err_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_red   <= rtdb_pkg::GAIN_ONE;
      gain_green <= rtdb_pkg::GAIN_ONE;
      gain_blue  <= rtdb_pkg::GAIN_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        rtdb_pkg::CFG_GAIN_RED:   gain_red   <= cfg_data;
        rtdb_pkg::CFG_GAIN_GREEN: gain_green <= cfg_data;
        rtdb_pkg::CFG_GAIN_BLUE:  gain_blue  <= cfg_data;
        default: ;
      endcase
    end
  end

  rtdb_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .final_pixel  (final_pixel),
    .result_ready (result_ready),
    .pixel_ready  (pixel_ready),
    .result_valid (result_valid),
    .end_of_frame (end_of_frame),
    .ctl          (ctl)
  );

  rtdb_blend u_blend_r (
    .clk (clk), .ctl (ctl), .expected (expected_red), .base (base_red),
    .gain (gain_red), .cand (cand_r), .cand_err (cerr_r)
  );
  rtdb_blend u_blend_g (
    .clk (clk), .ctl (ctl), .expected (expected_green), .base (base_green),
    .gain (gain_green), .cand (cand_g), .cand_err (cerr_g)
  );
  rtdb_blend u_blend_b (
    .clk (clk), .ctl (ctl), .expected (expected_blue), .base (base_blue),
    .gain (gain_blue), .cand (cand_b), .cand_err (cerr_b)
  );

  rtdb_density #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_dens_r (
    .clk (clk), .ctl (ctl), .cand (cand_r), .cand_err (cerr_r),
    .density (dens_r), .trans (tr_r), .err (err_r)
  );
  rtdb_density #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_dens_g (
    .clk (clk), .ctl (ctl), .cand (cand_g), .cand_err (cerr_g),
    .density (dens_g), .trans (tr_g), .err (err_g)
  );
  rtdb_density #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_dens_b (
    .clk (clk), .ctl (ctl), .cand (cand_b), .cand_err (cerr_b),
    .density (dens_b), .trans (tr_b), .err (err_b)
  );

  // a fault on any channel blanks the whole pixel
  assign status              = err_r | err_g | err_b;
  assign density_red         = status ? '0 : dens_r;
  assign density_green       = status ? '0 : dens_g;
  assign density_blue        = status ? '0 : dens_b;
  assign transmittance_red   = status ? '0 : tr_r;
  assign transmittance_green = status ? '0 : tr_g;
  assign transmittance_blue  = status ? '0 : tr_b;

  // back-pressure only reaches the input once every stage is full
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !pixel_ready |-> (result_valid && !result_ready))
    else $error("pixel_ready low without a stalled result");

  // a clean pixel never carries a zero candidate
  a_nonzero_cand: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !status) |->
      (transmittance_red != '0 && transmittance_green != '0 && transmittance_blue != '0))
    else $error("zero transmittance on a result without domain error");

  // density of a non-zero Q0.16 value stays within sixteen bits of log10 range
  a_dens_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !status) |->
      (density_red <= 16'd39457 && density_green <= 16'd39457 &&
       density_blue <= 16'd39457))
    else $error("density beyond the range of a non-zero transmittance");

endmodule
